/* hdl/spq_pkg.sv */
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants of the stable priority queue: field widths,
// status codes and the control bundle that runs along the cell chain.
// ----------------------------------------------------------------------------
package spq_pkg;

   localparam int CAPACITY_DEFAULT = 16;

   localparam int DATA_W   = 32;
   localparam int PRIO_W   = 16;
   localparam int COUNT_W  = 5;
   localparam int STATUS_W = 2;

   typedef enum logic [0:0] {
      OP_PUSH = 1'b0,
      OP_POP  = 1'b1
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_POP_EMPTY = 2'd1,
      STATUS_PUSH_FULL = 2'd2
   } status_type;

   // control that every cell sees in the same cycle
   typedef struct packed {
      logic                     push;
      logic                     pop;
      logic signed [DATA_W-1:0] data;
      logic signed [PRIO_W-1:0] prio;
   } chain_ctl_type;

endpackage

/* hdl/spq_cell.sv */
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted shift chain. On a push it keeps its entry, takes
// the new one or takes its left neighbor's; on a pop it takes its right
// neighbor's entry.
// ----------------------------------------------------------------------------
module spq_cell #(
   parameter int CNT_W = 5,
   parameter int INDEX = 0
) (
   input  logic                                 clock,
   input  spq_pkg::chain_ctl_type               ctl,
   input  logic [CNT_W-1:0]                     count,
   input  logic                                 left_keep,
   input  logic signed [spq_pkg::DATA_W-1:0]    left_data,
   input  logic signed [spq_pkg::PRIO_W-1:0]    left_prio,
   input  logic signed [spq_pkg::DATA_W-1:0]    right_data,
   input  logic signed [spq_pkg::PRIO_W-1:0]    right_prio,
   output logic                                 keep,
   output logic signed [spq_pkg::DATA_W-1:0]    slot_data,
   output logic signed [spq_pkg::PRIO_W-1:0]    slot_prio,
   output logic signed [spq_pkg::DATA_W-1:0]    next_data,
   output logic signed [spq_pkg::PRIO_W-1:0]    next_prio
);

   logic signed [spq_pkg::DATA_W-1:0] data_ff, data_in;
   logic signed [spq_pkg::PRIO_W-1:0] prio_ff, prio_in;
   logic                              occupied;

   assign occupied = (count > CNT_W'(INDEX));
   // stored entries at or above the new priority stay ahead of it
   assign keep     = occupied && (prio_ff >= ctl.prio);

   always_comb begin
      data_in = data_ff;
      prio_in = prio_ff;
      if (ctl.push && !keep) begin
         if (left_keep) begin
            data_in = ctl.data;
            prio_in = ctl.prio;
         end else begin
            data_in = left_data;
            prio_in = left_prio;
         end
      end else if (ctl.pop) begin
         data_in = right_data;
         prio_in = right_prio;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      prio_ff <= prio_in;
   end

   assign slot_data = data_ff;
   assign slot_prio = prio_ff;
   assign next_data = data_in;
   assign next_prio = prio_in;

endmodule

/* hdl/stable_priority_queue_unit.sv */
// ----------------------------------------------------------------------------
// stable_priority_queue_unit
// Bounded priority queue held as a sorted chain of cells, head in cell 0.
// ----------------------------------------------------------------------------
// Usage:
//   The req channel carries one operation per item: tuser selects push or
//   pop, tdata holds the entry's data and priority (ignored on pop). A push
//   lands behind every stored entry of equal or higher priority, so equal
//   priorities leave first-in first-out. A pop removes the head.
//   Every item yields exactly one rsp item describing the queue after the
//   operation: head data and priority (zero when empty), the entry count,
//   the empty flag and a status (ok, pop on empty, push dropped when full).
//   The rsp item is registered at the edge that takes the req item.
//   Throughput is one item per cycle unless the receiver stalls; all cells
//   compare against the incoming priority and shift in the same cycle.
//   When the receiver stalls, the rsp register holds and req_tready drops
//   until it is taken; a req item is taken in the same cycle the held rsp
//   item leaves.
//   Reset clears the entry count and the rsp valid flag; slot contents are
//   never read above the count and need no clearing.
// ----------------------------------------------------------------------------
module stable_priority_queue_unit #(
   parameter int CAPACITY = spq_pkg::CAPACITY_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // entry_data[31:0], entry_priority[47:32]
   input  logic [0:0]  req_tuser,   // operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // head_data[31:0], head_priority[47:32],
                                    // entry_count[52:48], zero fill[55:53]
   output logic [2:0]  rsp_tuser    // queue_empty[0], status[2:1]
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic [CNT_W-1:0]  count_ff, count_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic signed [spq_pkg::DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic signed [spq_pkg::PRIO_W-1:0] rsp_prio_ff, rsp_prio_in;
   logic [spq_pkg::COUNT_W-1:0]       rsp_count_ff, rsp_count_in;
   logic                              rsp_empty_ff, rsp_empty_in;
   spq_pkg::status_type               rsp_status_ff, rsp_status_in;

   logic                   accept;
   logic                   is_pop;
   logic                   full;
   logic                   empty;
   spq_pkg::chain_ctl_type ctl;

   logic                              keep_w      [CAPACITY];
   logic signed [spq_pkg::DATA_W-1:0] slot_data_w [CAPACITY];
   logic signed [spq_pkg::PRIO_W-1:0] slot_prio_w [CAPACITY];
   logic signed [spq_pkg::DATA_W-1:0] next_data_w [CAPACITY];
   logic signed [spq_pkg::PRIO_W-1:0] next_prio_w [CAPACITY];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign is_pop     = (spq_pkg::op_type'(req_tuser[0]) == spq_pkg::OP_POP);
   assign full       = (count_ff == CNT_W'(CAPACITY));
   assign empty      = (count_ff == '0);

   always_comb begin
      ctl.push = accept && !is_pop && !full;
      ctl.pop  = accept && is_pop && !empty;
      ctl.data = req_tdata[31:0];
      ctl.prio = req_tdata[47:32];
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic                              lkeep;
      logic signed [spq_pkg::DATA_W-1:0] ldata, rdata;
      logic signed [spq_pkg::PRIO_W-1:0] lprio, rprio;

      if (i == 0) begin : g_first
         assign lkeep = 1'b1;
         assign ldata = ctl.data;
         assign lprio = ctl.prio;
      end else begin : g_inner
         assign lkeep = keep_w[i-1];
         assign ldata = slot_data_w[i-1];
         assign lprio = slot_prio_w[i-1];
      end

      // the top cell is beyond the count after a pop, its content is free
      if (i == CAPACITY - 1) begin : g_last
         assign rdata = slot_data_w[i];
         assign rprio = slot_prio_w[i];
      end else begin : g_below
         assign rdata = slot_data_w[i+1];
         assign rprio = slot_prio_w[i+1];
      end

      spq_cell #(
         .CNT_W (CNT_W),
         .INDEX (i)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .count      (count_ff),
         .left_keep  (lkeep),
         .left_data  (ldata),
         .left_prio  (lprio),
         .right_data (rdata),
         .right_prio (rprio),
         .keep       (keep_w[i]),
         .slot_data  (slot_data_w[i]),
         .slot_prio  (slot_prio_w[i]),
         .next_data  (next_data_w[i]),
         .next_prio  (next_prio_w[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (ctl.push) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctl.pop) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_prio_in   = rsp_prio_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_empty_in  = rsp_empty_ff;
      rsp_status_in = rsp_status_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_empty_in = (count_in == '0);
         rsp_count_in = spq_pkg::COUNT_W'(count_in);
         if (count_in == '0) begin
            rsp_data_in = '0;
            rsp_prio_in = '0;
         end else begin
            rsp_data_in = next_data_w[0];
            rsp_prio_in = next_prio_w[0];
         end
         if (is_pop && empty) begin
            rsp_status_in = spq_pkg::STATUS_POP_EMPTY;
         end else if (!is_pop && full) begin
            rsp_status_in = spq_pkg::STATUS_PUSH_FULL;
         end else begin
            rsp_status_in = spq_pkg::STATUS_OK;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff   <= rsp_data_in;
      rsp_prio_ff   <= rsp_prio_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_empty_ff  <= rsp_empty_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_count_ff, rsp_prio_ff, rsp_data_ff};
   assign rsp_tuser  = {rsp_status_ff, rsp_empty_ff};

endmodule

/* hdl/spq_checker.sv */
// ----------------------------------------------------------------------------
// spq_checker
// Port-level checks of the priority queue's result channel, bound to the
// top level.
// ----------------------------------------------------------------------------
module spq_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [55:0] rsp_tdata,
   input logic [2:0]  rsp_tuser
);

   // no result item appears straight out of reset
   a_reset_quiet : assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result item valid right after reset");

   a_status_code : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser[2:1] == spq_pkg::STATUS_OK ||
                      rsp_tuser[2:1] == spq_pkg::STATUS_POP_EMPTY ||
                      rsp_tuser[2:1] == spq_pkg::STATUS_PUSH_FULL))
      else $error("undefined status code");

   // an empty flag implies a zero count and zero head fields
   a_empty_match : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |->
         (rsp_tdata[52:48] == 5'd0 && rsp_tdata[47:0] == 48'd0))
      else $error("empty flag disagrees with count or head");

   a_pop_empty : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[2:1] == spq_pkg::STATUS_POP_EMPTY) |-> rsp_tuser[0])
      else $error("pop on empty reported with a non-empty queue");

   a_stall_hold : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("stalled result item changed");

endmodule

bind stable_priority_queue_unit spq_checker u_spq_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

/* dv/stable_priority_queue_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stable_priority_queue_unit_tb
// Self-checking bench for the sorted priority queue. A scoreboard keeps its
// own sorted copy of the queue, works out the head, count and status for every
// accepted item and checks each rsp item in order. Stimulus is a short
// directed part followed by random fill, drain and mixed runs, with random
// idling on both sides and one long receiver hold-off.
// ----------------------------------------------------------------------------
module stable_priority_queue_unit_tb;

   localparam int CAPACITY     = spq_pkg::CAPACITY_DEFAULT;
   localparam int RANDOM_ITEMS = 1130;
   localparam int HOLD_CYCLES  = 80;

   typedef struct {
      logic [spq_pkg::DATA_W-1:0]  head_data;
      logic [spq_pkg::PRIO_W-1:0]  head_prio;
      logic                        queue_empty;
      logic [spq_pkg::COUNT_W-1:0] entry_count;
      spq_pkg::status_type         status;
   } queue_view_type;

   class spq_scoreboard;
      logic signed [spq_pkg::DATA_W-1:0] held_data[$];
      logic signed [spq_pkg::PRIO_W-1:0] held_prio[$];
      queue_view_type                    expected_views[$];
      int errors, checked, pushes, pops, dropped, empty_pops, deepest;

      function void note_request(spq_pkg::op_type op,
                                 logic signed [spq_pkg::DATA_W-1:0] d,
                                 logic signed [spq_pkg::PRIO_W-1:0] p);
         queue_view_type v;
         int pos;
         v.status = spq_pkg::STATUS_OK;
         if (op == spq_pkg::OP_PUSH) begin
            pushes++;
            if (held_prio.size() >= CAPACITY) begin
               v.status = spq_pkg::STATUS_PUSH_FULL;
               dropped++;
            end else begin
               // stable insert: behind every entry of equal or higher priority
               pos = 0;
               while (pos < held_prio.size() && held_prio[pos] >= p) pos++;
               held_prio.insert(pos, p);
               held_data.insert(pos, d);
            end
         end else begin
            pops++;
            if (held_prio.size() == 0) begin
               v.status = spq_pkg::STATUS_POP_EMPTY;
               empty_pops++;
            end else begin
               void'(held_prio.pop_front());
               void'(held_data.pop_front());
            end
         end
         if (held_prio.size() == 0) begin
            v.head_data   = '0;
            v.head_prio   = '0;
            v.queue_empty = 1'b1;
         end else begin
            v.head_data   = held_data[0];
            v.head_prio   = held_prio[0];
            v.queue_empty = 1'b0;
         end
         v.entry_count = spq_pkg::COUNT_W'(held_prio.size());
         if (held_prio.size() > deepest) deepest = held_prio.size();
         expected_views.push_back(v);
      endfunction

      function void compare_field(string name, logic [31:0] exp_val,
                                  logic [31:0] act_val);
         if (exp_val !== act_val) begin
            errors++;
            $display("%0t: %s mismatch, expected %h actual %h", $time, name,
                     exp_val, act_val);
         end
      endfunction

      function void check_response(logic [55:0] tdata, logic [2:0] tuser);
         queue_view_type v;
         if (expected_views.size() == 0) begin
            errors++;
            $display("%0t: unexpected rsp item, expected none actual %h/%h",
                     $time, tdata, tuser);
            return;
         end
         v = expected_views.pop_front();
         checked++;
         compare_field("head_data", v.head_data, tdata[31:0]);
         compare_field("head_priority", v.head_prio, tdata[47:32]);
         compare_field("entry_count", v.entry_count, tdata[52:48]);
         compare_field("queue_empty", v.queue_empty, tuser[0]);
         compare_field("status", v.status, tuser[2:1]);
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [47:0] req_tdata;   // entry_data[31:0], entry_priority[47:32]
   logic [0:0]  req_tuser;   // operation
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [55:0] rsp_tdata;   // head_data[31:0], head_priority[47:32],
                             // entry_count[52:48], zero fill[55:53]
   logic [2:0]  rsp_tuser;   // queue_empty[0], status[2:1]

   spq_scoreboard sb;
   bit req_idle_on;
   bit rsp_idle_on;
   bit hold_request;

   stable_priority_queue_unit #(.CAPACITY(CAPACITY)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("stable_priority_queue_unit test failed");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            sb.note_request(spq_pkg::op_type'(req_tuser), req_tdata[31:0],
                            req_tdata[47:32]);
         if (rsp_tvalid && rsp_tready)
            sb.check_response(rsp_tdata, rsp_tuser);
      end
   end

   // receiver: random stalls, plus one long hold-off on request
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else begin
            rsp_tready <= !(rsp_idle_on && $urandom_range(0, 99) < 35);
         end
      end
   end

   task automatic send_item(input spq_pkg::op_type op,
                            input logic [spq_pkg::DATA_W-1:0] d,
                            input logic [spq_pkg::PRIO_W-1:0] p);
      @(negedge clock);
      while (req_idle_on && $urandom_range(0, 99) < 35) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {p, d};
      do @(posedge clock); while (!req_tready);
   endtask

   // mostly narrow ranges so equal priorities are common
   function automatic logic [spq_pkg::PRIO_W-1:0] pick_priority();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return spq_pkg::PRIO_W'($urandom_range(0, 4) - 2);
      if (r < 70) return spq_pkg::PRIO_W'($urandom);
      if (r < 85) begin
         case ($urandom_range(0, 3))
            0:       return 16'sh7fff;
            1:       return 16'sh8000;
            2:       return '1;
            default: return '0;
         endcase
      end
      return spq_pkg::PRIO_W'($urandom_range(0, 200) - 100);
   endfunction

   initial begin
      int push_pct;
      sb = new();
      req_idle_on  = 1'b1;
      rsp_idle_on  = 1'b1;
      hold_request = 1'b0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = spq_pkg::OP_PUSH;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty pop, extreme entries, ties, fill to full and overflow
      send_item(spq_pkg::OP_POP, 32'h1234_5678, 16'h0001);
      send_item(spq_pkg::OP_PUSH, 32'h7fff_ffff, 16'sh7fff);
      send_item(spq_pkg::OP_PUSH, 32'h8000_0000, 16'sh8000);
      send_item(spq_pkg::OP_PUSH, 32'h0000_0000, 16'h0000);
      send_item(spq_pkg::OP_PUSH, 32'hffff_ffff, 16'h0000);
      send_item(spq_pkg::OP_PUSH, 32'h0000_0001, 16'h0000);
      send_item(spq_pkg::OP_POP, 32'hffff_ffff, 16'hffff);
      for (int i = 0; i < CAPACITY - 4; i++)
         send_item(spq_pkg::OP_PUSH, 32'h1000_0000 + i, spq_pkg::PRIO_W'(i % 3));
      send_item(spq_pkg::OP_PUSH, 32'hdead_beef, 16'sh7fff);

      // random: runs that lean to filling, draining or neither
      push_pct = 50;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 40 == 0) begin
            case ($urandom_range(0, 2))
               0:       push_pct = 85;
               1:       push_pct = 15;
               default: push_pct = 50;
            endcase
         end
         // a long stretch with no idling on either side
         req_idle_on = !(n >= 400 && n < 700);
         rsp_idle_on = req_idle_on;
         if (n == 750) hold_request = 1'b1;
         send_item(($urandom_range(0, 99) < push_pct) ? spq_pkg::OP_PUSH
                                                      : spq_pkg::OP_POP,
                   $urandom, pick_priority());
      end
      @(negedge clock);
      req_tvalid <= 1'b0;

      while (sb.expected_views.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("ran %0d pushes (%0d dropped when full) and %0d pops (%0d on empty)",
               sb.pushes, sb.dropped, sb.pops, sb.empty_pops);
      $display("deepest queue %0d of %0d, %0d rsp items checked, %0d mismatches",
               sb.deepest, CAPACITY, sb.checked, sb.errors);
      if (sb.errors == 0) begin
         $display("stable_priority_queue_unit test passed");
      end else begin
         $display("stable_priority_queue_unit test failed");
      end
      $finish;
   end

endmodule
